// ===== rtl/core/qed_pkg.sv =====
// ----------------------------------------------------------------------------
// qed_pkg
// Shared sizes, codes, types and fp16 helpers of the embedding row dequantizer.
// ----------------------------------------------------------------------------
package qed_pkg;

   localparam int VOCAB_MAX    = 1024;
   localparam int DIM_MAX      = 64;
   localparam int SCALE_DEPTH  = 8192;
   localparam int WEIGHT_DEPTH = 131072;
   localparam int CB_DEPTH     = 16;

   localparam int MODE_W     = 3;
   localparam int TOKEN_W    = 16;
   localparam int ADDR_W     = 17;
   localparam int WDATA_W    = 16;
   localparam int FMT_W      = 4;
   localparam int VOCAB_W    = 11;
   localparam int DIM_W      = 7;
   localparam int GRP_W      = 7;
   localparam int PAIR_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int TOK_IDX_W = $clog2(VOCAB_MAX);
   localparam int VMAX_W    = $clog2(VOCAB_MAX + 1);
   localparam int IDX_W     = $clog2(DIM_MAX);
   localparam int SIDX_W    = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
   localparam int WADDR_W   = $clog2(WEIGHT_DEPTH);
   localparam int CB_W      = $clog2(CB_DEPTH);
   localparam int DIVC_W    = $clog2(DIM_W);
   localparam int MAG_W     = 41;
   localparam int EXP_W     = 10;

   localparam logic [DIM_W-1:0] DIM_TOP = DIM_W'(DIM_MAX & ~1);

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WR_WEIGHT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WR_SCALE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WR_ZP    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WR_CB    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOCAB  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIM    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP  = 2'd3;

   // format codes
   localparam logic [FMT_W-1:0] FMT_FP16 = 4'd0;
   localparam logic [FMT_W-1:0] FMT_NF4  = 4'd13;

   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;
   localparam logic [EXP_W-1:0] EXP_FIX_BASE = 10'd143;

   typedef enum logic [1:0] {SCL_TENSOR, SCL_TOKEN, SCL_GROUP} scaling_type;
   typedef enum logic [1:0] {WK_HALF, WK_BYTE, WK_NIBBLE} wkind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_ELEM, ST_RD_HI, ST_CALC, ST_NORM, ST_MUL, ST_STORE, ST_ZERO
   } st_type;

   function automatic scaling_type fmt_scaling(logic [FMT_W-1:0] fmt);
      scaling_type s;
      unique case (fmt)
         4'd1, 4'd4, 4'd7, 4'd10: s = SCL_TENSOR;
         4'd2, 4'd5, 4'd8, 4'd11: s = SCL_TOKEN;
         default:                 s = SCL_GROUP;
      endcase
      return s;
   endfunction

   function automatic wkind_type fmt_kind(logic [FMT_W-1:0] fmt);
      wkind_type k;
      priority if (fmt == FMT_FP16) k = WK_HALF;
      else if (fmt <= 4'd6)         k = WK_BYTE;
      else                          k = WK_NIBBLE;
      return k;
   endfunction

   function automatic logic fmt_signed(logic [FMT_W-1:0] fmt);
      return ((fmt >= 4'd1) && (fmt <= 4'd3)) || ((fmt >= 4'd7) && (fmt <= 4'd9));
   endfunction

   // fp16 bits to fp32 bits, exact; NaN payload kept as is
   function automatic logic [31:0] half_to_single(logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] man;
      logic [3:0] p;
      logic [9:0] mn;
      logic [7:0] e;
      logic [31:0] r;
      ex = h[14:10];
      man = h[9:0];
      p = '0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) p = 4'(i);
      end
      mn = man << (4'd10 - p);
      e = 8'd103 + 8'(p);
      if (ex == 5'd0) begin
         r = (man == 10'd0) ? {h[15], 31'b0} : {h[15], e, mn, 13'b0};
      end else if (ex == 5'd31) begin
         r = {h[15], 8'hFF, man, 13'b0};
      end else begin
         r = {h[15], 8'(ex) + 8'd112, man, 13'b0};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/qed_if.sv =====
// ----------------------------------------------------------------------------
// qed channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qed_req_if import qed_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [TOKEN_W-1:0]    token_id;
   logic [ADDR_W-1:0]     address;
   logic [WDATA_W-1:0]    write_data;
   modport source (output valid, mode, token_id, address, write_data, input ready);
   modport sink   (input valid, mode, token_id, address, write_data, output ready);
endinterface

interface qed_rsp_if import qed_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [31:0]           value_even;
   logic [31:0]           value_odd;
   logic [PAIR_W-1:0]     pair_index;
   logic                  last_pair;
   modport source (output valid, value_even, value_odd, pair_index, last_pair, input ready);
   modport sink   (input valid, value_even, value_odd, pair_index, last_pair, output ready);
endinterface

interface qed_csr_if import qed_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/quantized_embedding_row_dequant_unit.sv =====
// ----------------------------------------------------------------------------
// quantized_embedding_row_dequant_unit
// Embedding row lookup with fp16/int/nf4 weights dequantized to fp32 pairs.
// ----------------------------------------------------------------------------
// A lookup finds the groups per row by restoring division, then reads and
// decodes each element; integer formats use the shared normalize/round unit
// (shift by 8 or 1 bit a cycle; at most once before, once after the multiply).
// Out-of-range tokens and unused formats stream zero pairs, one a cycle while
// the receiver is ready. One request at a time. Synchronous active-high reset
// restores configuration and control, not the weight/scale/zp/codebook stores.
module quantized_embedding_row_dequant_unit import qed_pkg::*; (
   input logic         clock,
   input logic         reset,
   qed_req_if.sink     req_ch,
   qed_rsp_if.source   rsp_ch,
   qed_csr_if.sink     csr_ch
);

   // configuration registers
   logic [FMT_W-1:0]   cfg_fmt_ff;
   logic [VOCAB_W-1:0] cfg_vocab_ff;
   logic [6:0]         cfg_dim_ff;
   logic [6:0]         cfg_group_ff;

   // sequencer
   st_type st_ff, st_in;
   logic [FMT_W-1:0]     fmt_ff, fmt_in;
   logic [TOK_IDX_W-1:0] tok_ff, tok_in;
   logic [DIM_W-1:0]     d_ff, d_in;
   logic [GRP_W-1:0]     g_ff, g_in;
   logic [DIM_W-1:0]     gpr_ff, gpr_in;      // groups per row
   logic [DIM_W-1:0]     dv_ff, dv_in;        // dividend shifter
   logic [GRP_W-1:0]     rem_ff, rem_in;
   logic [DIVC_W-1:0]    divc_ff, divc_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [GRP_W-1:0]     gpos_ff, gpos_in;
   logic [IDX_W-1:0]     grp_ff, grp_in;
   logic [WADDR_W-1:0]   base_ff, base_in;

   // shared normalize/round unit and operands
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic signed [EXP_W-1:0] exp_ff, exp_in;
   logic                 sgn_ff, sgn_in;
   logic                 phase_ff, phase_in;  // 0 integer/difference, 1 product
   logic [31:0]          a_ff, a_in;
   logic [31:0]          res_ff, res_in;
   logic [31:0]          even_ff, even_in;
   logic [7:0]           lo_ff, lo_in;

   // response register
   logic                 rv_ff, rv_in;
   logic [31:0]          re_ff, re_in;
   logic [31:0]          ro_ff, ro_in;
   logic [PAIR_W-1:0]    rp_ff, rp_in;
   logic                 rl_ff, rl_in;

   // stores
   logic [7:0]  wmem [WEIGHT_DEPTH];
   logic [15:0] smem [SCALE_DEPTH];
   logic [15:0] zmem [SCALE_DEPTH];
   logic [15:0] cb_ff [CB_DEPTH];
   logic [7:0]  wrd_ff;
   logic [15:0] srd_ff;
   logic [15:0] zrd_ff;

   logic req_take, csr_take;
   logic [WADDR_W-1:0] wmem_ra;
   logic [SIDX_W-1:0]  pidx;
   logic               rd_en;

   assign req_ch.ready = (st_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_take = csr_ch.valid && csr_ch.ready;

   assign rsp_ch.valid      = rv_ff;
   assign rsp_ch.value_even = re_ff;
   assign rsp_ch.value_odd  = ro_ff;
   assign rsp_ch.pair_index = rp_ff;
   assign rsp_ch.last_pair  = rl_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_fmt_ff   <= FMT_FP16;
         cfg_vocab_ff <= VOCAB_W'(1024);
         cfg_dim_ff   <= 7'd64;
         cfg_group_ff <= 7'd64;
      end else if (csr_take) begin
         unique case (csr_ch.index)
            REG_FORMAT: cfg_fmt_ff   <= csr_ch.data[FMT_W-1:0];
            REG_VOCAB:  cfg_vocab_ff <= csr_ch.data[VOCAB_W-1:0];
            REG_DIM:    cfg_dim_ff   <= csr_ch.data[6:0];
            REG_GROUP:  cfg_group_ff <= csr_ch.data[6:0];
            default:    ;
         endcase
      end
   end

   // ---------------------------------------------------------------- stores
   // Read addresses: weight byte of the current element (high byte of an
   // fp16 weight in ST_RD_HI), scale/zero-point entry of its scaling group.
   logic [IDX_W:0] woff;
   always_comb begin
      unique case (fmt_kind(fmt_ff))
         WK_HALF:   woff = {idx_ff, (st_ff == ST_RD_HI)};
         WK_BYTE:   woff = {1'b0, idx_ff};
         WK_NIBBLE: woff = {2'b0, idx_ff[IDX_W-1:1]};
         default:   woff = '0;
      endcase
      wmem_ra = base_ff + WADDR_W'(woff);
      unique case (fmt_scaling(fmt_ff))
         SCL_TENSOR: pidx = '0;
         SCL_TOKEN:  pidx = SIDX_W'(tok_ff);
         SCL_GROUP:  pidx = SIDX_W'(tok_ff * gpr_ff + grp_ff);
         default:    pidx = '0;
      endcase
      rd_en = (st_ff == ST_ELEM) || (st_ff == ST_RD_HI);
   end

   always_ff @(posedge clock) begin
      if (req_take && (req_ch.mode == MODE_WR_WEIGHT)) begin
         wmem[req_ch.address[WADDR_W-1:0]] <= req_ch.write_data[7:0];
      end
      if (rd_en) begin
         wrd_ff <= wmem[wmem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (req_ch.mode == MODE_WR_SCALE)) begin
         smem[SIDX_W'(req_ch.address)] <= req_ch.write_data;
      end
      if (rd_en) begin
         srd_ff <= smem[pidx];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (req_ch.mode == MODE_WR_ZP)) begin
         zmem[SIDX_W'(req_ch.address)] <= req_ch.write_data;
      end
      if (rd_en) begin
         zrd_ff <= zmem[pidx];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (req_ch.mode == MODE_WR_CB)) begin
         cb_ff[req_ch.address[CB_W-1:0]] <= req_ch.write_data;
      end
   end

   // ---------------------------------------------------------------- datapath
   // row geometry at lookup start
   logic [DIM_W-1:0]  d_calc;
   logic [VMAX_W-1:0] vmax;
   logic [DIM_W:0]    bpr;
   logic              zero_row;

   // element decode
   logic [3:0]        nib;
   logic signed [8:0] qs;
   logic [7:0]        qu;
   logic [7:0]        qabs;
   logic [MAG_W-1:0]  qfix, zfix;
   logic [4:0]        ze;

   // rounding
   logic [23:0]       m24;
   logic [24:0]       m25;
   logic              rnd_inc;
   logic [31:0]       fp_norm;

   // multiply operands
   logic [31:0]       sf;
   logic [10:0]       ms;
   logic              a_nan, a_inf, a_zero, s_nan, s_inf, s_zero;

   // division trial
   logic [GRP_W:0]    trial;

   always_comb begin
      d_calc = cfg_dim_ff[DIM_W-1:0] & ~DIM_W'(1);
      if (d_calc < DIM_W'(2)) d_calc = DIM_W'(2);
      if (d_calc > DIM_TOP) d_calc = DIM_TOP;
      vmax = (VMAX_W'(cfg_vocab_ff) > VMAX_W'(VOCAB_MAX)) ? VMAX_W'(VOCAB_MAX)
                                                          : VMAX_W'(cfg_vocab_ff);
      zero_row = (req_ch.token_id >= TOKEN_W'(vmax)) || (cfg_fmt_ff > FMT_NF4);
      unique case (fmt_kind(cfg_fmt_ff))
         WK_HALF:   bpr = {d_calc, 1'b0};
         WK_BYTE:   bpr = {1'b0, d_calc};
         WK_NIBBLE: bpr = {2'b0, d_calc[DIM_W-1:1]};
         default:   bpr = '0;
      endcase

      nib  = idx_ff[0] ? wrd_ff[3:0] : wrd_ff[7:4];
      qu   = (fmt_kind(fmt_ff) == WK_BYTE) ? wrd_ff : {4'b0, nib};
      qs   = (fmt_kind(fmt_ff) == WK_BYTE) ? {wrd_ff[7], wrd_ff} : {{5{nib[3]}}, nib};
      qabs = qs[8] ? 8'(-qs) : qs[7:0];
      qfix = MAG_W'(qu) << 24;
      ze   = zrd_ff[14:10];
      zfix = (ze == 5'd0) ? MAG_W'(zrd_ff[9:0])
                          : (MAG_W'({1'b1, zrd_ff[9:0]}) << (ze - 5'd1));

      m24 = mag_ff[MAG_W-1 -: 24];
      rnd_inc = mag_ff[MAG_W-25] && ((|mag_ff[MAG_W-26:0]) || m24[0]);
      m25 = {1'b0, m24} + 25'(rnd_inc);
      fp_norm = {sgn_ff, 8'(exp_ff + EXP_W'(m25[24])), m25[24] ? 23'b0 : m25[22:0]};

      sf     = half_to_single(srd_ff);
      ms     = {(srd_ff[14:10] != 5'd0), srd_ff[9:0]};
      a_nan  = (a_ff[30:23] == 8'hFF) && (a_ff[22:0] != '0);
      a_inf  = (a_ff[30:23] == 8'hFF) && (a_ff[22:0] == '0);
      a_zero = (a_ff[30:0] == '0);
      s_nan  = (srd_ff[14:10] == 5'd31) && (srd_ff[9:0] != '0);
      s_inf  = (srd_ff[14:10] == 5'd31) && (srd_ff[9:0] == '0);
      s_zero = (srd_ff[14:0] == '0);

      trial = {rem_ff, dv_ff[DIM_W-1]};
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      st_in = st_ff;
      fmt_in = fmt_ff;  tok_in = tok_ff;  d_in = d_ff;  g_in = g_ff;
      gpr_in = gpr_ff;  dv_in = dv_ff;  rem_in = rem_ff;  divc_in = divc_ff;
      idx_in = idx_ff;  gpos_in = gpos_ff;  grp_in = grp_ff;  base_in = base_ff;
      mag_in = mag_ff;  exp_in = exp_ff;  sgn_in = sgn_ff;  phase_in = phase_ff;
      a_in = a_ff;  res_in = res_ff;  even_in = even_ff;  lo_in = lo_ff;
      re_in = re_ff;  ro_in = ro_ff;  rp_in = rp_ff;  rl_in = rl_ff;
      // drop the response once taken
      rv_in = rv_ff && !rsp_ch.ready;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_take && (req_ch.mode == MODE_LOOKUP)) begin
               fmt_in  = cfg_fmt_ff;
               tok_in  = req_ch.token_id[TOK_IDX_W-1:0];
               d_in    = d_calc;
               g_in    = (cfg_group_ff == 7'd0) ? GRP_W'(1) : cfg_group_ff[GRP_W-1:0];
               base_in = WADDR_W'(req_ch.token_id[TOK_IDX_W-1:0] * bpr);
               idx_in  = '0;
               gpos_in = '0;
               grp_in  = '0;
               dv_in   = d_calc;
               rem_in  = '0;
               gpr_in  = '0;
               divc_in = DIVC_W'(DIM_W - 1);
               st_in   = zero_row ? ST_ZERO : ST_DIV;
            end
         end

         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            dv_in = dv_ff << 1;
            if (trial >= {1'b0, g_ff}) begin
               rem_in = GRP_W'(trial - {1'b0, g_ff});
               gpr_in = {gpr_ff[DIM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[GRP_W-1:0];
               gpr_in = {gpr_ff[DIM_W-2:0], 1'b0};
            end
            if (divc_ff == '0) begin
               st_in = ST_ELEM;
            end else begin
               divc_in = divc_ff - DIVC_W'(1);
            end
         end

         ST_ELEM: begin
            st_in = (fmt_ff == FMT_FP16) ? ST_RD_HI : ST_CALC;
         end

         ST_RD_HI: begin
            lo_in = wrd_ff;
            st_in = ST_CALC;
         end

         ST_CALC: begin
            phase_in = 1'b0;
            exp_in   = EXP_FIX_BASE;
            if (fmt_ff == FMT_FP16) begin
               res_in = half_to_single({wrd_ff, lo_ff});
               st_in  = ST_STORE;
            end else if (fmt_ff == FMT_NF4) begin
               res_in = half_to_single(cb_ff[nib]);
               st_in  = ST_STORE;
            end else if (fmt_signed(fmt_ff)) begin
               mag_in = MAG_W'(qabs) << 24;
               sgn_in = qs[8];
               a_in   = '0;
               st_in  = (qs == 9'sd0) ? ST_MUL : ST_NORM;
            end else if (ze == 5'd31) begin
               // zero point is inf or NaN
               a_in  = (zrd_ff[9:0] != '0) ? (half_to_single(zrd_ff) | FP_QUIET_BIT)
                                           : {!zrd_ff[15], 8'hFF, 23'b0};
               st_in = ST_MUL;
            end else begin
               priority if (!zrd_ff[15] && (zfix > qfix)) begin
                  mag_in = zfix - qfix;
                  sgn_in = 1'b1;
               end else if (!zrd_ff[15]) begin
                  mag_in = qfix - zfix;
                  sgn_in = 1'b0;
               end else begin
                  mag_in = qfix + zfix;
                  sgn_in = 1'b0;
               end
               a_in  = '0;
               st_in = (mag_in == '0) ? ST_MUL : ST_NORM;
            end
         end

         ST_NORM: begin
            if (mag_ff[MAG_W-1]) begin
               if (phase_ff) begin
                  res_in = fp_norm;
                  st_in  = ST_STORE;
               end else begin
                  a_in  = fp_norm;
                  st_in = ST_MUL;
               end
            end else if (mag_ff[MAG_W-1 -: 8] == '0) begin
               mag_in = mag_ff << 8;
               exp_in = exp_ff - EXP_W'(8);
            end else begin
               mag_in = mag_ff << 1;
               exp_in = exp_ff - EXP_W'(1);
            end
         end

         ST_MUL: begin
            st_in = ST_STORE;
            priority if (a_nan) begin
               res_in = a_ff;
            end else if (s_nan) begin
               res_in = sf | FP_QUIET_BIT;
            end else if ((a_inf && s_zero) || (a_zero && s_inf)) begin
               res_in = FP_DEFAULT_NAN;
            end else if (a_inf || s_inf) begin
               res_in = {a_ff[31] ^ srd_ff[15], 8'hFF, 23'b0};
            end else if (a_zero || s_zero) begin
               res_in = {a_ff[31] ^ srd_ff[15], 31'b0};
            end else begin
               mag_in   = MAG_W'({1'b1, a_ff[22:0]} * ms);
               sgn_in   = a_ff[31] ^ srd_ff[15];
               exp_in   = (srd_ff[14:10] != 5'd0)
                        ? EXP_W'(a_ff[30:23]) + EXP_W'(srd_ff[14:10]) - EXP_W'(8)
                        : EXP_W'(a_ff[30:23]) - EXP_W'(7);
               phase_in = 1'b1;
               st_in    = ST_NORM;
            end
         end

         ST_STORE: begin
            if (!idx_ff[0]) begin
               even_in = res_ff;
            end
            // hold an odd element until the response register frees up
            if (!idx_ff[0] || !rv_ff || rsp_ch.ready) begin
               if (idx_ff[0]) begin
                  rv_in = 1'b1;
                  re_in = even_ff;
                  ro_in = res_ff;
                  rp_in = PAIR_W'(idx_ff >> 1);
                  rl_in = ({1'b0, idx_ff} == d_ff - DIM_W'(1));
               end
               if ({1'b0, idx_ff} == d_ff - DIM_W'(1)) begin
                  st_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  if (gpos_ff + GRP_W'(1) == g_ff) begin
                     gpos_in = '0;
                     grp_in  = grp_ff + IDX_W'(1);
                  end else begin
                     gpos_in = gpos_ff + GRP_W'(1);
                  end
                  st_in = ST_ELEM;
               end
            end
         end

         ST_ZERO: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in = 1'b1;
               re_in = '0;
               ro_in = '0;
               rp_in = PAIR_W'(idx_ff >> 1);
               rl_in = ({1'b0, idx_ff} == d_ff - DIM_W'(2));
               if ({1'b0, idx_ff} == d_ff - DIM_W'(2)) begin
                  st_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(2);
               end
            end
         end

         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         rv_ff   <= 1'b0;
         idx_ff  <= '0;
         gpos_ff <= '0;
         grp_ff  <= '0;
         g_ff    <= GRP_W'(1);
         d_ff    <= DIM_W'(2);
         divc_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         rv_ff   <= rv_in;
         idx_ff  <= idx_in;
         gpos_ff <= gpos_in;
         grp_ff  <= grp_in;
         g_ff    <= g_in;
         d_ff    <= d_in;
         divc_ff <= divc_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff  <= fmt_in;
      tok_ff  <= tok_in;
      gpr_ff  <= gpr_in;
      dv_ff   <= dv_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
      mag_ff  <= mag_in;
      exp_ff  <= exp_in;
      sgn_ff  <= sgn_in;
      a_ff    <= a_in;
      res_ff  <= res_in;
      even_ff <= even_in;
      lo_ff   <= lo_in;
      re_ff   <= re_in;
      ro_ff   <= ro_in;
      rp_ff   <= rp_in;
      rl_ff   <= rl_in;
   end

   // ---------------------------------------------------------------- checks
   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_NORM) |-> (mag_ff != '0))
      else $error("normalizer entered with zero magnitude");

   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_NORM) && mag_ff[MAG_W-1] |-> (exp_ff > 0) && (exp_ff < EXP_W'(255)))
      else $error("rounded exponent out of normal range");

   a_group_pos: assert property (@(posedge clock) disable iff (reset)
      gpos_ff < g_ff)
      else $error("position within group reached group size");

   a_last_pair: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) && rl_ff |-> (DIM_W'({rp_ff, 1'b1}) == d_ff - DIM_W'(1)))
      else $error("last pair flagged at wrong pair index");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding row dequantizer testbench
// Configures formats, row sizes and scaling, loads weights, scales, zero
// points and the codebook through write requests, then looks up rows and
// checks every returned fp32 pair against a scoreboard that dequantizes the
// same rows in binary32 with round-to-nearest-even.
// ----------------------------------------------------------------------------
module testbench;
   import qed_pkg::*;

   localparam logic [FMT_W-1:0] FMT_INT8_LAST  = 4'd3;
   localparam logic [FMT_W-1:0] FMT_UINT8_LAST = 4'd6;
   localparam logic [FMT_W-1:0] FMT_INT4_LAST  = 4'd9;
   localparam logic [FMT_W-1:0] FMT_UINT4_LAST = 4'd12;
   localparam logic [MODE_W-1:0] MODE_NOP_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_NOP_LAST  = 3'd7;
   localparam logic [31:0] SINGLE_INF = 32'h7F80_0000;
   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [31:0]       value_even;
      logic [31:0]       value_odd;
      logic [PAIR_W-1:0] pair_index;
      logic              last_pair;
   } pair_t;

   // Tracks the stores and registers and predicts the pairs of each lookup.
   class row_dequant_scoreboard;
      bit [7:0]  weight_mem [WEIGHT_DEPTH];
      bit [15:0] scale_mem [SCALE_DEPTH];
      bit [15:0] zp_mem [SCALE_DEPTH];
      bit [15:0] cb_mem [CB_DEPTH];
      bit [FMT_W-1:0]   fmt_r;
      bit [VOCAB_W-1:0] vocab_r;
      bit [DIM_W-1:0]   dim_r;
      bit [GRP_W-1:0]   grp_r;
      pair_t pending_pairs[$];
      int mismatches;
      int pairs_checked;
      int lookups;

      function new();
         fmt_r = FMT_FP16;
         vocab_r = 11'd1024;
         dim_r = 7'd64;
         grp_r = 7'd64;
      endfunction

      function bit [31:0] widen_half(bit [15:0] h);
         bit [10:0] mm;
         bit [7:0] e;
         mm = {1'b0, h[9:0]};
         if (h[14:10] == 5'd0) begin
            if (mm == 11'd0) return {h[15], 31'b0};
            e = 8'd113;
            while (!mm[10]) begin
               mm = mm << 1;
               e = e - 8'd1;
            end
            return {h[15], e, mm[9:0], 13'b0};
         end
         if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'b0};
         return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'b0};
      endfunction

      // finite, zero or normal single only
      function real single_to_real(bit [31:0] x);
         if (x[30:0] == 31'd0) return $bitstoreal({x[31], 63'b0});
         return $bitstoreal({x[31], 11'(x[30:23]) + 11'd896, x[22:0], 29'b0});
      endfunction

      // round a double to binary32, nearest even
      function bit [31:0] round_single(real r);
         bit [63:0] b;
         bit [24:0] mant;
         int ue;
         b = $realtobits(r);
         if (b[62:52] == 11'd0) return {b[63], 31'b0};
         ue = int'(b[62:52]) - 1023;
         mant = {2'b01, b[51:29]} + 25'(b[28] && ((|b[27:0]) || b[29]));
         if (mant[24]) begin
            mant = mant >> 1;
            ue++;
         end
         if (ue > 127) return {b[63], SINGLE_INF[30:0]};
         return {b[63], 8'(ue + 127), mant[22:0]};
      endfunction

      function bit is_nan(bit [31:0] x);
         return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      endfunction

      function bit is_inf(bit [31:0] x);
         return x[30:0] == SINGLE_INF[30:0];
      endfunction

      // a is an integer, never NaN or infinite
      function bit [31:0] fsub(bit [31:0] a, bit [31:0] z);
         if (is_nan(z)) return z | FP_QUIET_BIT;
         if (is_inf(z)) return {~z[31], SINGLE_INF[30:0]};
         return round_single(single_to_real(a) - single_to_real(z));
      endfunction

      function bit [31:0] fmul(bit [31:0] a, bit [31:0] s);
         if (is_nan(a)) return a | FP_QUIET_BIT;
         if (is_nan(s)) return s | FP_QUIET_BIT;
         if (is_inf(a) || is_inf(s)) begin
            if (a[30:0] == 31'd0 || s[30:0] == 31'd0) return FP_DEFAULT_NAN;
            return {a[31] ^ s[31], SINGLE_INF[30:0]};
         end
         return round_single(single_to_real(a) * single_to_real(s));
      endfunction

      function bit [7:0] wbyte(int unsigned a);
         return weight_mem[a % WEIGHT_DEPTH];
      endfunction

      function bit [31:0] dequant_element(int unsigned tok, int unsigned d, int unsigned idx);
         int unsigned g, pidx, a, q, scaling;
         bit [7:0] b;
         bit [31:0] s, z;
         int v;
         g = (grp_r == 0) ? 1 : grp_r;
         if (fmt_r == FMT_FP16) begin
            a = tok * d * 2 + idx * 2;
            return widen_half({wbyte(a + 1), wbyte(a)});
         end
         if (fmt_r <= FMT_UINT8_LAST) q = wbyte(tok * d + idx);
         else begin
            b = wbyte(tok * (d / 2) + idx / 2);
            q = idx[0] ? b[3:0] : b[7:4];
         end
         if (fmt_r == FMT_NF4) return widen_half(cb_mem[q % CB_DEPTH]);
         scaling = (fmt_r - 1) % 3;
         if (scaling == 0) pidx = 0;
         else if (scaling == 1) pidx = tok;
         else pidx = tok * (d / g) + idx / g;
         pidx = pidx % SCALE_DEPTH;
         s = widen_half(scale_mem[pidx]);
         z = widen_half(zp_mem[pidx]);
         if (fmt_r <= FMT_INT8_LAST) begin
            v = (q >= 128) ? int'(q) - 256 : int'(q);
            return fmul(round_single(real'(v)), s);
         end
         if (fmt_r <= FMT_UINT8_LAST)
            return fmul(fsub(round_single(real'(q)), z), s);
         if (fmt_r <= FMT_INT4_LAST) begin
            v = (q >= 8) ? int'(q) - 16 : int'(q);
            return fmul(round_single(real'(v)), s);
         end
         return fmul(fsub(round_single(real'(q)), z), s);
      endfunction

      function void note_config(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            REG_FORMAT: fmt_r = data[FMT_W-1:0];
            REG_VOCAB:  vocab_r = data[VOCAB_W-1:0];
            REG_DIM:    dim_r = data[DIM_W-1:0];
            default:    grp_r = data[GRP_W-1:0];
         endcase
      endfunction

      function void note_request(bit [MODE_W-1:0] mode, bit [TOKEN_W-1:0] tok,
                                 bit [ADDR_W-1:0] addr, bit [WDATA_W-1:0] data);
         int unsigned d, vmax;
         bit zero;
         pair_t p;
         case (mode)
            MODE_WR_WEIGHT: weight_mem[addr] = data[7:0];
            MODE_WR_SCALE:  scale_mem[addr % SCALE_DEPTH] = data;
            MODE_WR_ZP:     zp_mem[addr % SCALE_DEPTH] = data;
            MODE_WR_CB:     cb_mem[addr % CB_DEPTH] = data;
            MODE_LOOKUP: begin
               lookups++;
               d = dim_r & ~1;
               if (d < 2) d = 2;
               if (d > (DIM_MAX & ~1)) d = DIM_MAX & ~1;
               vmax = (vocab_r > VOCAB_MAX) ? VOCAB_MAX : vocab_r;
               zero = (tok >= vmax) || (fmt_r > FMT_NF4);
               for (int k = 0; k < d / 2; k++) begin
                  p.value_even = zero ? 32'd0 : dequant_element(tok, d, 2 * k);
                  p.value_odd  = zero ? 32'd0 : dequant_element(tok, d, 2 * k + 1);
                  p.pair_index = PAIR_W'(k);
                  p.last_pair  = (k + 1 == d / 2);
                  pending_pairs.push_back(p);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(pair_t got);
         pair_t want;
         if (pending_pairs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pair %0d: %h %h last %b",
               got.pair_index, got.value_even, got.value_odd, got.last_pair);
            return;
         end
         want = pending_pairs.pop_front();
         pairs_checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pair mismatch: expected %h %h k=%0d last=%b, got %h %h k=%0d last=%b",
                  want.value_even, want.value_odd, want.pair_index, want.last_pair,
                  got.value_even, got.value_odd, got.pair_index, got.last_pair);
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   qed_req_if req_ch();
   qed_rsp_if rsp_ch();
   qed_csr_if csr_ch();

   row_dequant_scoreboard sb = new();
   bit idling_on = 1'b1;
   bit hold_rsp  = 1'b0;
   int idle_count = 0;
   int phases = 0;

   quantized_embedding_row_dequant_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Observe every handshake at the edge; drivers change inputs only after it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.mode, req_ch.token_id, req_ch.address, req_ch.write_data);
         if (csr_ch.valid && csr_ch.ready)
            sb.note_config(csr_ch.index, csr_ch.data);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.value_even, rsp_ch.value_odd,
                             rsp_ch.pair_index, rsp_ch.last_pair});
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready) || reset) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("timeout with %0d pairs outstanding", sb.pending_pairs.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Response sink: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one request and hold it until accepted; maybe idle first.
   task automatic send_req(logic [MODE_W-1:0] mode, logic [TOKEN_W-1:0] tok,
                           logic [ADDR_W-1:0] addr, logic [WDATA_W-1:0] data);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= mode;
      req_ch.token_id   <= tok;
      req_ch.address    <= addr;
      req_ch.write_data <= data;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Drop valid, drain all pairs, then give the block time to go idle.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly moderate fp16 values; now and then any pattern (inf, NaN, subnormal).
   function automatic logic [15:0] pick_half();
      if ($urandom_range(0, 5) == 0) return 16'($urandom);
      return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
   endfunction

   // Load one token's row and every scale and zero point that it reads.
   task automatic load_row(int unsigned fmt, int unsigned tok, int unsigned d, int unsigned g);
      int unsigned bpr, pidx;
      if (fmt > FMT_NF4) return;
      bpr = (fmt == FMT_FP16) ? 2 * d : (fmt <= FMT_UINT8_LAST) ? d : d / 2;
      for (int unsigned i = 0; i < bpr; i++)
         send_req(MODE_WR_WEIGHT, 16'($urandom), ADDR_W'(tok * bpr + i), 16'($urandom));
      if (fmt == FMT_FP16 || fmt == FMT_NF4) return;
      for (int unsigned i = 0; i < d; i++) begin
         case ((fmt - 1) % 3)
            0: pidx = 0;
            1: pidx = tok;
            default: pidx = tok * (d / g) + i / g;
         endcase
         if (i == 0 || ((fmt - 1) % 3 == 2 && i % g == 0)) begin
            // upper address bits wrap away
            send_req(MODE_WR_SCALE, 16'($urandom),
                     ADDR_W'(pidx % SCALE_DEPTH + SCALE_DEPTH * $urandom_range(0, 15)),
                     pick_half());
            if ((fmt > FMT_INT8_LAST && fmt <= FMT_UINT8_LAST) || fmt > FMT_INT4_LAST)
               send_req(MODE_WR_ZP, 16'($urandom),
                        ADDR_W'(pidx % SCALE_DEPTH + SCALE_DEPTH * $urandom_range(0, 15)),
                        $urandom_range(0, 3) == 0 ? pick_half()
                                                  : {6'b010110, 10'($urandom)});
         end
      end
   endtask

   // One setting: configure, load up to two rows, then look up rows.
   task automatic run_phase(logic [CSR_DATA_W-1:0] fmt_raw, logic [CSR_DATA_W-1:0] vocab_raw,
                            logic [CSR_DATA_W-1:0] dim_raw, logic [CSR_DATA_W-1:0] grp_raw,
                            int nlook);
      int unsigned fmt, vmax, d, g, ntok;
      int unsigned toks[2];
      int pick;
      settle();
      write_csr(REG_FORMAT, fmt_raw);
      write_csr(REG_VOCAB, vocab_raw);
      write_csr(REG_DIM, dim_raw);
      write_csr(REG_GROUP, grp_raw);
      phases++;
      fmt  = fmt_raw[FMT_W-1:0];
      vmax = (vocab_raw[VOCAB_W-1:0] > VOCAB_MAX) ? VOCAB_MAX : vocab_raw[VOCAB_W-1:0];
      d = dim_raw[DIM_W-1:0] & ~1;
      if (d < 2) d = 2;
      if (d > DIM_MAX) d = DIM_MAX;
      g = (grp_raw[GRP_W-1:0] == 0) ? 1 : grp_raw[GRP_W-1:0];
      ntok = (vmax == 0) ? 0 : (vmax == 1 || $urandom_range(0, 2) != 0) ? 1 : 2;
      if (ntok > 0) toks[0] = ($urandom_range(0, 1) == 0) ? vmax - 1 : $urandom_range(0, vmax - 1);
      if (ntok > 1) toks[1] = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, vmax - 1);
      for (int i = 0; i < ntok; i++) load_row(fmt, toks[i], d, g);
      for (int i = 0; i < nlook; i++) begin
         pick = $urandom_range(0, 9);
         if (ntok > 0 && pick < 7)
            send_req(MODE_LOOKUP, TOKEN_W'(toks[$urandom_range(0, ntok - 1)]),
                     17'($urandom), 16'($urandom));
         else if (pick < 9)
            // token at or above the vocabulary size
            send_req(MODE_LOOKUP, ($urandom_range(0, 2) == 0) ? 16'hFFFF
                        : TOKEN_W'($urandom_range(vmax, 65535)), 17'($urandom), 16'($urandom));
         else
            send_req(MODE_NOP_FIRST + MODE_W'($urandom_range(0, 2)), 16'($urandom),
                     17'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_LOOKUP;
      req_ch.token_id = '0;
      req_ch.address = '0;
      req_ch.write_data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_FORMAT;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the codebook; high address bits are ignored
      for (int i = 0; i < CB_DEPTH; i++)
         send_req(MODE_WR_CB, 16'($urandom), ADDR_W'(i + CB_DEPTH * $urandom_range(0, 8191)),
                  (i == 3) ? 16'h7C00 : (i == 7) ? 16'hFE01 : (i == 9) ? 16'h0001 : pick_half());

      // directed: each format family, extremes of the registers
      run_phase(FMT_FP16, 16'd1024, 16'd4, 16'd64, 3);
      run_phase(FMT_NF4, 16'd2047, 16'd3, 16'd0, 3);      // odd dim, group zero, vocab saturates
      run_phase(16'd1, 16'd1, 16'd0, 16'd1, 2);           // dim below minimum, single token
      run_phase(16'd3, 16'd5, 16'd6, 16'd4, 3);           // group not dividing the row
      run_phase(16'd6, 16'd1024, 16'd2, 16'd127, 2);
      run_phase(16'd11, 16'd0, 16'd4, 16'd2, 2);          // empty vocabulary
      run_phase(16'd15, 16'd8, 16'd127, 16'd5, 2);        // unused format, dim above maximum
      run_phase(16'hFFF9, 16'hF803, 16'hFF8A, 16'hFF83, 2); // unused upper bits set

      // random settings, mostly short rows
      for (int f = 1; f <= 14; f++)
         run_phase(16'($urandom_range(0, 15)), 16'($urandom_range(0, 2047)),
                   ($urandom_range(0, 5) == 0) ? 16'($urandom_range(18, 127))
                                               : 16'($urandom_range(0, 17)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 127))
                                               : 16'($urandom_range(0, 8)), 6);

      // long receiver hold-off on full rows while requests keep coming
      run_phase(16'd12, 16'd1024, 16'd64, 16'd8, 0);
      hold_rsp = 1'b1;
      run_phase(16'd12, 16'd1024, 16'd64, 16'd8, 0);
      for (int i = 0; i < 4; i++)
         send_req(MODE_LOOKUP, 16'($urandom_range(1024, 65535)), 17'($urandom), 16'($urandom));

      // closing part with no idling on either side
      idling_on = 1'b0;
      run_phase(16'd8, 16'd300, 16'd10, 16'd3, 6);
      run_phase(FMT_FP16, 16'd64, 16'd64, 16'd64, 3);
      settle();

      $display("covered %0d settings, %0d lookups, %0d pairs checked, %0d mismatches",
               phases, sb.lookups, sb.pairs_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_pairs.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
